// ===== rtl/cfq_pkg.sv =====
// ============================================================================
// cfq_pkg: shared types and constants of the circular FIFO queue
// Sizes, command and status codes, the controller state type and the
// command/status bundles between controller and datapath.
// ============================================================================
package cfq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W      = 5;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 3;
    localparam int OUT_W      = 32;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP    = 2'd2;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_STORED    = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_DEQUEUED  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_LISTED    = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_REPORT,
        OP_DUMP_START,
        OP_DUMP_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
        logic    last;
    } dp_cmd_t;

    typedef struct packed {
        logic is_empty;
        logic is_full;
        logic dump_at_tail;
        logic out_busy;
    } dp_stat_t;

    // Advance a ring index, wrapping after the last slot in use
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                  input logic [IDX_W-1:0] ring_last);
        logic [IDX_W-1:0] result;
        if (idx == ring_last)
        begin
            result = '0;
        end
        else
        begin
            result = idx + 1'b1;
        end
        return result;
    endfunction

endpackage

// ===== rtl/circular_fifo_queue.sv =====
// ============================================================================
// circular_fifo_queue: ring-buffer FIFO of signed words
// Top level joining the queue controller and the queue datapath.
// ============================================================================
// Usage: each input transaction carries a command (enqueue, dequeue, dump)
// and a push value. Enqueue and dequeue each give one result and sustain one
// transaction per cycle while results are taken; the result appears in the
// output register in the cycle after acceptance, and a new command is taken
// while that result is being taken. A dump loads its pointer from the head,
// then lists the elements, oldest first, with last set on the newest; input is
// held off until the final element is loaded. A dump of an empty queue gives
// one "empty" result. The ring of slots in use is set by capacity (zero acts
// as one, above the built depth of 16 acts as 16); writing it flushes the
// queue. The single read port of the slot memory sets the one-element-per-cycle
// dump rate while results are taken. Command code 3 is dropped with no result.
module circular_fifo_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              capacity_we,
    input  logic [cfq_pkg::CAP_W-1:0]         capacity,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cfq_pkg::CMD_W-1:0]         command,
    input  logic signed [cfq_pkg::OUT_W-1:0]  push_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cfq_pkg::STAT_W-1:0]        status,
    output logic signed [cfq_pkg::OUT_W-1:0]  data_out,
    output logic                              last
);

    cfq_pkg::dp_cmd_t  dp_cmd;   // operation for this cycle
    cfq_pkg::dp_stat_t dp_stat;  // queue and output register status

    // Controller: accept transactions, sequence dumps
    cfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .dp_stat  (dp_stat),
        .in_ready (in_ready),
        .dp_cmd   (dp_cmd)
    );

    // Datapath: slots, pointers and result register
    cfq_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity_we (capacity_we),
        .capacity    (capacity),
        .push_value  (push_value),
        .dp_cmd      (dp_cmd),
        .out_ready   (out_ready),
        .dp_stat     (dp_stat),
        .out_valid   (out_valid),
        .status      (status),
        .data_out    (data_out),
        .last        (last)
    );

`ifndef ASSERT_OFF
    // Hold off input while a result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while result stalled");

    // An enqueue produces a stored or overflow result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && command == cfq_pkg::CMD_ENQUEUE) |=>
        (out_valid && (status == cfq_pkg::ST_STORED || status == cfq_pkg::ST_OVERFLOW)
         && last))
        else $error("enqueue without matching result");

    // A dequeue produces a dequeued or underflow result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && command == cfq_pkg::CMD_DEQUEUE) |=>
        (out_valid && (status == cfq_pkg::ST_DEQUEUED || status == cfq_pkg::ST_UNDERFLOW)
         && last))
        else $error("dequeue without matching result");

    // Results other than listed and dequeued carry zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != cfq_pkg::ST_LISTED && status != cfq_pkg::ST_DEQUEUED)
        |-> (data_out == '0))
        else $error("nonzero data on status-only result");
`endif

endmodule

// ===== rtl/cfq_ctrl.sv =====
// ============================================================================
// cfq_ctrl: queue controller
// Decodes accepted commands into datapath operations and walks the
// dump sequence one listed element at a time.
// ============================================================================
module cfq_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [cfq_pkg::CMD_W-1:0]    command,
    input  cfq_pkg::dp_stat_t            dp_stat,
    output logic                         in_ready,
    output cfq_pkg::dp_cmd_t             dp_cmd
);

    cfq_pkg::state_t state_reg;
    cfq_pkg::state_t state_next;
    logic            accept;

    assign in_ready = (state_reg == cfq_pkg::S_IDLE) && !dp_stat.out_busy;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfq_pkg::S_IDLE:
            begin
                if (accept && command == cfq_pkg::CMD_DUMP && !dp_stat.is_empty)
                begin
                    state_next = cfq_pkg::S_DUMP;
                end
            end
            cfq_pkg::S_DUMP:
            begin
                if (!dp_stat.out_busy && dp_stat.dump_at_tail)
                begin
                    state_next = cfq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cfq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        dp_cmd.op     = cfq_pkg::OP_NONE;
        dp_cmd.status = cfq_pkg::ST_STORED;
        dp_cmd.last   = 1'b1;
        unique case (state_reg)
            cfq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        cfq_pkg::CMD_ENQUEUE:
                        begin
                            if (dp_stat.is_full)
                            begin
                                dp_cmd.op     = cfq_pkg::OP_REPORT;
                                dp_cmd.status = cfq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                dp_cmd.op     = cfq_pkg::OP_PUSH;
                                dp_cmd.status = cfq_pkg::ST_STORED;
                            end
                        end
                        cfq_pkg::CMD_DEQUEUE:
                        begin
                            if (dp_stat.is_empty)
                            begin
                                dp_cmd.op     = cfq_pkg::OP_REPORT;
                                dp_cmd.status = cfq_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                dp_cmd.op     = cfq_pkg::OP_POP;
                                dp_cmd.status = cfq_pkg::ST_DEQUEUED;
                            end
                        end
                        cfq_pkg::CMD_DUMP:
                        begin
                            if (dp_stat.is_empty)
                            begin
                                dp_cmd.op     = cfq_pkg::OP_REPORT;
                                dp_cmd.status = cfq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                dp_cmd.op     = cfq_pkg::OP_DUMP_START;
                            end
                        end
                        default:
                        begin
                            dp_cmd.op = cfq_pkg::OP_NONE;  // unused code: drop
                        end
                    endcase
                end
            end
            cfq_pkg::S_DUMP:
            begin
                if (!dp_stat.out_busy)
                begin
                    dp_cmd.op     = cfq_pkg::OP_DUMP_STEP;
                    dp_cmd.status = cfq_pkg::ST_LISTED;
                    dp_cmd.last   = dp_stat.dump_at_tail;
                end
            end
            default:
            begin
                dp_cmd.op = cfq_pkg::OP_NONE;
            end
        endcase
    end

endmodule

// ===== rtl/cfq_dpath.sv =====
// ============================================================================
// cfq_dpath: queue datapath
// Slot memory, head/tail/dump pointers, ring size and the result register.
// ============================================================================
module cfq_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               capacity_we,
    input  logic [cfq_pkg::CAP_W-1:0]          capacity,
    input  logic signed [cfq_pkg::OUT_W-1:0]   push_value,
    input  cfq_pkg::dp_cmd_t                   dp_cmd,
    input  logic                               out_ready,
    output cfq_pkg::dp_stat_t                  dp_stat,
    output logic                               out_valid,
    output logic [cfq_pkg::STAT_W-1:0]         status,
    output logic signed [cfq_pkg::OUT_W-1:0]   data_out,
    output logic                               last
);

    logic [cfq_pkg::DATA_WIDTH-1:0] mem [cfq_pkg::DEPTH];

    logic [cfq_pkg::IDX_W-1:0] head_reg;
    logic [cfq_pkg::IDX_W-1:0] head_next;
    logic [cfq_pkg::IDX_W-1:0] tail_reg;
    logic [cfq_pkg::IDX_W-1:0] tail_next;
    logic [cfq_pkg::IDX_W-1:0] dump_ptr_reg;
    logic [cfq_pkg::IDX_W-1:0] dump_ptr_next;
    logic [cfq_pkg::IDX_W-1:0] ring_last_reg;
    logic [cfq_pkg::IDX_W-1:0] ring_last_next;
    logic                      empty_reg;
    logic                      empty_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    logic [cfq_pkg::CAP_W-1:0] cap_minus_one;
    logic [cfq_pkg::IDX_W-1:0] tail_adv;
    logic [cfq_pkg::IDX_W-1:0] wr_addr;
    logic [cfq_pkg::IDX_W-1:0] rd_addr;
    logic                      load_out;
    logic                      do_read;

    logic [cfq_pkg::STAT_W-1:0]       status_reg;
    logic signed [cfq_pkg::OUT_W-1:0] data_out_reg;
    logic                             last_reg;

    assign cap_minus_one = capacity - 1'b1;
    assign tail_adv      = cfq_pkg::next_idx(tail_reg, ring_last_reg);
    assign wr_addr       = empty_reg ? '0 : tail_adv;
    assign rd_addr       = (dp_cmd.op == cfq_pkg::OP_POP) ? head_reg : dump_ptr_reg;
    assign do_read       = (dp_cmd.op == cfq_pkg::OP_POP) || (dp_cmd.op == cfq_pkg::OP_DUMP_STEP);
    assign load_out      = (dp_cmd.op == cfq_pkg::OP_PUSH) || (dp_cmd.op == cfq_pkg::OP_REPORT)
                           || do_read;

    // Ring size: zero acts as one slot, anything above the built depth as the depth
    always_comb
    begin
        if (capacity == '0)
        begin
            ring_last_next = '0;
        end
        else if (capacity > cfq_pkg::CAP_W'(cfq_pkg::DEPTH))
        begin
            ring_last_next = cfq_pkg::IDX_W'(cfq_pkg::DEPTH - 1);
        end
        else
        begin
            ring_last_next = cap_minus_one[cfq_pkg::IDX_W-1:0];
        end
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        empty_next    = empty_reg;
        dump_ptr_next = dump_ptr_reg;
        case (dp_cmd.op)
            cfq_pkg::OP_PUSH:
            begin
                tail_next  = wr_addr;
                empty_next = 1'b0;
                if (empty_reg)
                begin
                    head_next = '0;
                end
            end
            cfq_pkg::OP_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                end
                else
                begin
                    head_next = cfq_pkg::next_idx(head_reg, ring_last_reg);
                end
            end
            cfq_pkg::OP_DUMP_START:
            begin
                dump_ptr_next = head_reg;
            end
            cfq_pkg::OP_DUMP_STEP:
            begin
                dump_ptr_next = cfq_pkg::next_idx(dump_ptr_reg, ring_last_reg);
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            dump_ptr_reg  <= '0;
            ring_last_reg <= cfq_pkg::IDX_W'(cfq_pkg::DEPTH - 1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            dump_ptr_reg  <= dump_ptr_next;
            if (capacity_we)
            begin
                // New ring size: flush the queue
                ring_last_reg <= ring_last_next;
                head_reg      <= '0;
                tail_reg      <= '0;
                empty_reg     <= 1'b1;
            end
            else
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                empty_reg <= empty_next;
            end
        end
    end

    // Slot memory and result register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == cfq_pkg::OP_PUSH)
        begin
            mem[wr_addr] <= cfq_pkg::DATA_WIDTH'(push_value);
        end
        if (load_out)
        begin
            status_reg <= dp_cmd.status;
            last_reg   <= dp_cmd.last;
            if (do_read)
            begin
                data_out_reg <= cfq_pkg::OUT_W'(signed'(mem[rd_addr]));
            end
            else
            begin
                data_out_reg <= '0;
            end
        end
    end

    assign dp_stat.is_empty     = empty_reg;
    assign dp_stat.is_full      = !empty_reg && (tail_adv == head_reg);
    assign dp_stat.dump_at_tail = (dump_ptr_reg == tail_reg);
    assign dp_stat.out_busy     = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_out_reg;
    assign last      = last_reg;

endmodule

// ===== sim/tb_circular_fifo_queue.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_circular_fifo_queue: self-checking testbench of the circular FIFO queue
// Feeds enqueue, dequeue, dump and unused commands through the valid/ready
// input channel under several ring capacities. A behavioral queue model
// predicts every result, and a monitor checks each result transaction in
// order, with random idling on both channels and one long receiver hold-off.
// ============================================================================
module tb_circular_fifo_queue;

    localparam logic [cfq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 30;
    localparam int HOLD_CYCLES  = 150;

    // One input transaction waiting to be driven
    typedef struct {
        logic [cfq_pkg::CMD_W-1:0] cmd;
        logic [cfq_pkg::OUT_W-1:0] val;
    } queue_txn_t;

    // One predicted result transaction
    typedef struct {
        cfq_pkg::status_t          status;
        logic [cfq_pkg::OUT_W-1:0] data;
        logic                      last;
    } queue_result_t;

    logic                              clk         = 1'b0;
    logic                              rst_n       = 1'b0;
    logic                              capacity_we = 1'b0;
    logic [cfq_pkg::CAP_W-1:0]         capacity    = '0;
    logic                              in_valid    = 1'b0;
    logic                              in_ready;
    logic [cfq_pkg::CMD_W-1:0]         command     = '0;
    logic signed [cfq_pkg::OUT_W-1:0]  push_value  = '0;
    logic                              out_valid;
    logic                              out_ready   = 1'b0;
    logic [cfq_pkg::STAT_W-1:0]        status;
    logic signed [cfq_pkg::OUT_W-1:0]  data_out;
    logic                              last;

    // Model of the queue: ring contents, pointers and the capacity register
    logic [cfq_pkg::DATA_WIDTH-1:0]    model_slots [cfq_pkg::DEPTH];
    int unsigned                       model_head  = 0;
    int unsigned                       model_tail  = 0;
    logic                              model_empty = 1'b1;
    logic [cfq_pkg::CAP_W-1:0]         model_cap   = cfq_pkg::CAP_W'(cfq_pkg::DEPTH);

    queue_txn_t                        pending_txns [$];
    queue_result_t                     expected_results [$];

    int                                error_count = 0;
    int                                cycle_count = 0;
    logic                              in_fire_q   = 1'b0;
    logic                              out_fire_q  = 1'b0;
    int                                send_max_gap = 0;
    int                                recv_max_stall = 0;
    int                                send_wait   = 0;
    int                                recv_wait   = 0;
    logic                              rx_hold_req = 1'b0;
    int                                rx_hold_cnt = 0;

    circular_fifo_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity_we (capacity_we),
        .capacity    (capacity),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .push_value  (push_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .data_out    (data_out),
        .last        (last)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Queue model
    // ------------------------------------------------------------------------

    // Effective ring length: zero acts as one, anything above DEPTH as DEPTH
    function automatic int unsigned ring_len();
        if (model_cap == '0)
        begin
            return 1;
        end
        if (model_cap > cfq_pkg::CAP_W'(cfq_pkg::DEPTH))
        begin
            return cfq_pkg::DEPTH;
        end
        return model_cap;
    endfunction

    function automatic int unsigned ring_advance(input int unsigned idx);
        return (idx + 1 >= ring_len()) ? 0 : idx + 1;
    endfunction

    function automatic void add_expected(input cfq_pkg::status_t st,
                                         input logic [cfq_pkg::OUT_W-1:0] d,
                                         input logic l);
        queue_result_t r;
        r.status = st;
        r.data   = d;
        r.last   = l;
        expected_results.push_back(r);
    endfunction

    // Apply one accepted input transaction to the model and queue its results
    task automatic apply_queue_model(input logic [cfq_pkg::CMD_W-1:0] cmd,
                                     input logic [cfq_pkg::OUT_W-1:0] val);
        int unsigned idx;
        int          n;
        logic        at_end;
        case (cmd)
            cfq_pkg::CMD_ENQUEUE:
            begin
                if (!model_empty && ring_advance(model_tail) == model_head)
                begin
                    add_expected(cfq_pkg::ST_OVERFLOW, '0, 1'b1);
                end
                else
                begin
                    // First word after empty always lands in slot 0
                    if (model_empty)
                    begin
                        model_head  = 0;
                        model_tail  = 0;
                        model_empty = 1'b0;
                    end
                    else
                    begin
                        model_tail = ring_advance(model_tail);
                    end
                    model_slots[model_tail] = val;
                    add_expected(cfq_pkg::ST_STORED, '0, 1'b1);
                end
            end
            cfq_pkg::CMD_DEQUEUE:
            begin
                if (model_empty)
                begin
                    add_expected(cfq_pkg::ST_UNDERFLOW, '0, 1'b1);
                end
                else
                begin
                    add_expected(cfq_pkg::ST_DEQUEUED, model_slots[model_head], 1'b1);
                    if (model_head == model_tail)
                    begin
                        model_head  = 0;
                        model_tail  = 0;
                        model_empty = 1'b1;
                    end
                    else
                    begin
                        model_head = ring_advance(model_head);
                    end
                end
            end
            cfq_pkg::CMD_DUMP:
            begin
                if (model_empty)
                begin
                    add_expected(cfq_pkg::ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    idx = model_head;
                    n   = 0;
                    while (n < cfq_pkg::DEPTH)
                    begin
                        at_end = (idx == model_tail) || (n + 1 >= cfq_pkg::DEPTH);
                        add_expected(cfq_pkg::ST_LISTED, model_slots[idx], at_end);
                        n++;
                        if (at_end)
                        begin
                            break;
                        end
                        idx = ring_advance(idx);
                    end
                end
            end
            default:
            begin
                // Unused command: drop it, no result
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver: present pending transactions at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        queue_txn_t t;
        if (in_valid && !in_fire_q)
        begin
            // Hold the payload until the transaction is taken
        end
        else if (send_wait > 0)
        begin
            send_wait--;
            in_valid <= 1'b0;
        end
        else if (pending_txns.size() > 0)
        begin
            t = pending_txns.pop_front();
            in_valid   <= 1'b1;
            command    <= t.cmd;
            push_value <= t.val;
            // Gap to insert once this transaction has been taken
            send_wait = $urandom_range(0, send_max_gap);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall the result channel at random, or hold off on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_hold_req)
        begin
            rx_hold_cnt = HOLD_CYCLES;
            rx_hold_req = 1'b0;
        end
        if (out_fire_q)
        begin
            recv_wait = $urandom_range(0, recv_max_stall);
        end
        if (rx_hold_cnt > 0)
        begin
            rx_hold_cnt--;
            out_ready <= 1'b0;
        end
        else if (recv_wait > 0)
        begin
            recv_wait--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results, then feed accepted inputs to the model
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        queue_result_t e;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_circular_fifo_queue: FAIL");
            $finish;
        end
        else
        begin
            in_fire_q  <= in_valid && in_ready;
            out_fire_q <= out_valid && out_ready;
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d data_out %0d last %0d",
                           status, data_out, last);
                    error_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (status !== e.status)
                    begin
                        $error("status: expected %0d, actual %0d", e.status, status);
                        error_count++;
                    end
                    if (data_out !== e.data)
                    begin
                        $error("data_out: expected %0d, actual %0d",
                               $signed(e.data), data_out);
                        error_count++;
                    end
                    if (last !== e.last)
                    begin
                        $error("last: expected %0d, actual %0d", e.last, last);
                        error_count++;
                    end
                end
            end
            if (rst_n && in_valid && in_ready)
            begin
                apply_queue_model(command, push_value);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_txn(input logic [cfq_pkg::CMD_W-1:0] cmd,
                            input logic [cfq_pkg::OUT_W-1:0] val);
        queue_txn_t t;
        t.cmd = cmd;
        t.val = val;
        pending_txns.push_back(t);
    endtask

    // Wait until every transaction is driven and every result has arrived,
    // then let a dropped command or a trailing dump step run out
    task automatic drain_queue();
        while (pending_txns.size() != 0 || in_valid)
        begin
            @(negedge clk);
        end
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write capacity while the block is idle; the write also flushes the ring
    task automatic write_capacity(input logic [cfq_pkg::CAP_W-1:0] value);
        @(negedge clk);
        capacity_we <= 1'b1;
        capacity    <= value;
        @(negedge clk);
        capacity_we <= 1'b0;
        model_cap   = value;
        model_head  = 0;
        model_tail  = 0;
        model_empty = 1'b1;
    endtask

    function automatic logic [cfq_pkg::OUT_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal command streams with random data, plus bursts that fill
    // the ring past full and drain it back out
    task automatic queue_random_txns(input int count);
        int made;
        int pick;
        int k;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                for (k = 0; k <= int'(ring_len()); k++)
                begin
                    push_txn(cfq_pkg::CMD_ENQUEUE, pick_word());
                end
                push_txn(cfq_pkg::CMD_DUMP, pick_word());
                for (k = 0; k <= int'(ring_len()); k++)
                begin
                    push_txn(cfq_pkg::CMD_DEQUEUE, pick_word());
                end
                made += 2 * int'(ring_len()) + 3;
            end
            else
            begin
                if (pick < 50)
                begin
                    push_txn(cfq_pkg::CMD_ENQUEUE, pick_word());
                end
                else if (pick < 82)
                begin
                    push_txn(cfq_pkg::CMD_DEQUEUE, pick_word());
                end
                else if (pick < 96)
                begin
                    push_txn(cfq_pkg::CMD_DUMP, pick_word());
                end
                else
                begin
                    push_txn(CMD_UNUSED, pick_word());
                end
                made++;
            end
        end
    endtask

    task automatic run_random_phase(input logic [cfq_pkg::CAP_W-1:0] cap, input int max_gap,
                                    input int max_stall, input int count,
                                    input logic hold_receiver);
        write_capacity(cap);
        send_max_gap   = max_gap;
        recv_max_stall = max_stall;
        // Hold off the receiver while the sender streams, so the block backs up
        if (hold_receiver)
        begin
            rx_hold_req = 1'b1;
        end
        queue_random_txns(count);
        drain_queue();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset capacity: empty cases, extreme words,
        // a dropped command and draining to underflow
        send_max_gap   = 3;
        recv_max_stall = 3;
        push_txn(cfq_pkg::CMD_DUMP,    32'h0);
        push_txn(cfq_pkg::CMD_DEQUEUE, 32'h0);
        push_txn(cfq_pkg::CMD_ENQUEUE, 32'h7FFF_FFFF);
        push_txn(cfq_pkg::CMD_ENQUEUE, 32'h8000_0000);
        push_txn(cfq_pkg::CMD_ENQUEUE, 32'h0000_0000);
        push_txn(cfq_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF);
        push_txn(cfq_pkg::CMD_DUMP,    32'h0);
        push_txn(CMD_UNUSED,           32'h1234_5678);
        push_txn(cfq_pkg::CMD_DEQUEUE, 32'hFFFF_FFFF);
        push_txn(cfq_pkg::CMD_DEQUEUE, 32'h0);
        push_txn(cfq_pkg::CMD_DEQUEUE, 32'h0);
        push_txn(cfq_pkg::CMD_DEQUEUE, 32'h0);
        push_txn(cfq_pkg::CMD_DEQUEUE, 32'h0);
        drain_queue();

        // Small ring: fill, overflow, full dump, wrap around the end
        write_capacity(5'd3);
        push_txn(cfq_pkg::CMD_ENQUEUE, 32'h0000_0011);
        push_txn(cfq_pkg::CMD_ENQUEUE, 32'h0000_0022);
        push_txn(cfq_pkg::CMD_ENQUEUE, 32'h0000_0033);
        push_txn(cfq_pkg::CMD_ENQUEUE, 32'h0000_0044);
        push_txn(cfq_pkg::CMD_DUMP,    32'h0);
        push_txn(cfq_pkg::CMD_DEQUEUE, 32'h0);
        push_txn(cfq_pkg::CMD_ENQUEUE, 32'h0000_0055);
        push_txn(cfq_pkg::CMD_DUMP,    32'h0);
        drain_queue();

        // Capacity of zero acts as one slot
        write_capacity(5'd0);
        push_txn(cfq_pkg::CMD_ENQUEUE, 32'hDEAD_BEEF);
        push_txn(cfq_pkg::CMD_ENQUEUE, 32'h0BAD_F00D);
        push_txn(cfq_pkg::CMD_DUMP,    32'h0);
        push_txn(cfq_pkg::CMD_DEQUEUE, 32'h0);
        drain_queue();

        // Random phases over the capacity range, with and without idling
        run_random_phase(5'd0,  7, 7, 30, 1'b0);
        run_random_phase(5'd31, 0, 0, 30, 1'b0);
        run_random_phase(5'd1,  7, 3, 30, 1'b0);
        run_random_phase(5'd16, 0, 7, 40, 1'b1);
        run_random_phase(5'd5,  3, 7, 40, 1'b0);
        run_random_phase(5'd16, 7, 0, 40, 1'b0);
        run_random_phase(5'd10, 7, 7, 40, 1'b0);
        run_random_phase(5'd21, 0, 0, 30, 1'b0);
        run_random_phase(cfq_pkg::CAP_W'($urandom_range(1, cfq_pkg::DEPTH)), 7, 7, 40, 1'b0);

        if (error_count == 0)
        begin
            $display("tb_circular_fifo_queue: PASS");
        end
        else
        begin
            $display("tb_circular_fifo_queue: FAIL");
        end
        $finish;
    end

endmodule
